### rtl/core/bmss_pkg.sv
// package: constants, command codes and cell control type of the member set
`timescale 1ns / 1ps
package bmss_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MEMBER_W = 16;
    localparam int STEP_W   = 32;
    localparam int CMD_W    = 3;
    localparam int COUNT_W  = 7;

    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_LIST   = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_STEP   = 3'd5
    } t_cmd;

    typedef struct packed {
        logic load_key;
        logic load_last;
        logic shift;
        logic wrap;
    } t_cell_ctl;

endpackage

### rtl/core/bmss_if.sv
// valid/ready channel interfaces for command and result beats
`timescale 1ns / 1ps
interface bmss_in_if;
    logic                          valid;
    logic                          ready;
    logic [bmss_pkg::CMD_W-1:0]    command;
    logic [bmss_pkg::MEMBER_W-1:0] member_index;
    logic [bmss_pkg::STEP_W-1:0]   suggested_step;

    modport source (output valid, command, member_index, suggested_step, input ready);
    modport sink   (input valid, command, member_index, suggested_step, output ready);
endinterface

interface bmss_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [bmss_pkg::COUNT_W-1:0]  member_count;
    logic [bmss_pkg::MEMBER_W-1:0] listed_member;
    logic                          listed_valid;
    logic                          last;
    logic [bmss_pkg::STEP_W-1:0]   current_step;
    logic                          status;

    modport source (output valid, found, member_count, listed_member, listed_valid, last,
                    current_step, status, input ready);
    modport sink   (input valid, found, member_count, listed_member, listed_valid, last,
                    current_step, status, output ready);
endinterface

### rtl/core/bmss_cell.sv
// one table cell: holds a member, compares it, takes a new value, the last member's or its neighbor's
`timescale 1ns / 1ps
module bmss_cell (
    input  logic                          i_clk,
    input  bmss_pkg::t_cell_ctl           i_ctl,
    input  logic [bmss_pkg::MEMBER_W-1:0] i_key,
    input  logic [bmss_pkg::MEMBER_W-1:0] i_last_val,
    input  logic [bmss_pkg::MEMBER_W-1:0] i_next_val,
    input  logic [bmss_pkg::MEMBER_W-1:0] i_head_val,
    output logic [bmss_pkg::MEMBER_W-1:0] o_val,
    output logic                          o_match
);
    import bmss_pkg::*;

    logic [MEMBER_W-1:0] r_val;
    logic [MEMBER_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.load_key) begin
            n_val = i_key;
        end else if (i_ctl.load_last) begin
            n_val = i_last_val;
        end else if (i_ctl.shift) begin
            n_val = i_ctl.wrap ? i_head_val : i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val   = r_val;
    assign o_match = (r_val == i_key);

endmodule

### rtl/core/bmss_step.sv
// running minimum of suggested time steps
`timescale 1ns / 1ps
module bmss_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_suggest,
    input  logic [bmss_pkg::STEP_W-1:0] i_step,
    output logic [bmss_pkg::STEP_W-1:0] o_step
);
    import bmss_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_comb begin
        n_step = r_step;
        if (i_clear) begin
            n_step = STEP_MAX;
        end else if (i_suggest && (i_step < r_step)) begin
            n_step = i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_MAX;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_step = r_step;

endmodule

### rtl/core/bounded_member_set_with_min_step_unit.sv
// top level: bounded member set with running minimum step
`timescale 1ns / 1ps
// Keeps up to CAPACITY distinct 16-bit members in a row of cells plus a running
// minimum step. One command beat is taken at a time. Query, add, remove, clear and
// suggest give their single result beat in the result state, after the compare and
// execute states, and the next command is taken the cycle after that result is taken.
// List gives its first beat in the result state too and then one beat per cycle while
// the sink is ready, because the cell row rotates by one entry for every beat taken and
// is back in order after the last.
module bounded_member_set_with_min_step_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmss_in_if.sink    i_in,
    bmss_out_if.source o_out
);
    import bmss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [MEMBER_W-1:0] r_key;
    logic [STEP_W-1:0]   r_sug;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CAPACITY-1:0] r_match;
    logic                r_found, n_found;
    logic                r_status, n_status;
    logic                r_list, n_list;

    logic [MEMBER_W-1:0] w_val   [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_below;
    logic [CAPACITY-1:0] w_is_last;
    logic [CAPACITY-1:0] w_is_slot;
    t_cell_ctl           w_ctl   [CAPACITY];
    logic [MEMBER_W-1:0] w_last_val;
    logic [STEP_W-1:0]   w_step;
    logic                w_in_acc, w_out_acc;
    logic                w_any;
    logic                w_full;
    logic                w_do_add, w_do_rem, w_rotate;
    logic                w_list_ne, w_list_end;
    logic                w_clear, w_suggest;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;
    assign w_any     = |r_match;
    assign w_full    = (r_total >= CNT_W'(CAPACITY));
    assign w_do_add  = (r_state == S_EXEC) && (t_cmd'(r_cmd) == CMD_ADD) && !w_any && !w_full;
    assign w_do_rem  = (r_state == S_EXEC) && (t_cmd'(r_cmd) == CMD_REMOVE) && w_any;
    assign w_list_ne = r_list && (r_total != '0);
    assign w_list_end = (r_cnt == (r_total - CNT_W'(1)));
    assign w_rotate  = (r_state == S_OUT) && w_out_acc && w_list_ne;
    assign w_clear   = (r_state == S_EXEC) && (t_cmd'(r_cmd) == CMD_CLEAR);
    assign w_suggest = (r_state == S_EXEC) && (t_cmd'(r_cmd) == CMD_STEP);

    // cell row
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [MEMBER_W-1:0] w_next;
            if (g == CAPACITY - 1) begin : g_end
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_val[g+1];
            end

            assign w_below[g]   = (CNT_W'(g) < r_total);
            assign w_is_last[g] = (CNT_W'(g + 1) == r_total);
            assign w_is_slot[g] = (CNT_W'(g) == r_total);

            always_comb begin
                w_ctl[g].load_key  = w_do_add && w_is_slot[g];
                w_ctl[g].load_last = w_do_rem && r_match[g];
                w_ctl[g].shift     = w_rotate && w_below[g];
                w_ctl[g].wrap      = w_is_last[g];
            end

            bmss_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_key      (r_key),
                .i_last_val (w_last_val),
                .i_next_val (w_next),
                .i_head_val (w_val[0]),
                .o_val      (w_val[g]),
                .o_match    (w_match[g])
            );
        end
    endgenerate

    // value of the last occupied cell
    always_comb begin
        w_last_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_last_val = w_last_val | (w_is_last[i] ? w_val[i] : '0);
        end
    end

    bmss_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_suggest (w_suggest),
        .i_step    (r_sug),
        .o_step    (w_step)
    );

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_cnt    = r_cnt;
        n_found  = r_found;
        n_status = r_status;
        n_list   = r_list;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_found  = 1'b0;
                n_status = 1'b0;
                n_list   = 1'b0;
                n_cnt    = '0;
                case (t_cmd'(r_cmd))
                    CMD_QUERY:  n_found = w_any;
                    CMD_ADD: begin
                        n_status = !w_any && w_full;
                        if (w_do_add) begin
                            n_total = r_total + CNT_W'(1);
                        end
                    end
                    CMD_REMOVE: begin
                        if (w_do_rem) begin
                            n_total = r_total - CNT_W'(1);
                        end
                    end
                    CMD_LIST:   n_list  = 1'b1;
                    CMD_CLEAR:  n_total = '0;
                    default:    n_found = 1'b0;
                endcase
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_acc) begin
                    if (w_list_ne && !w_list_end) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_cnt    <= '0;
            r_found  <= 1'b0;
            r_status <= 1'b0;
            r_list   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_cnt    <= n_cnt;
            r_found  <= n_found;
            r_status <= n_status;
            r_list   <= n_list;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd <= i_in.command;
            r_key <= i_in.member_index;
            r_sug <= i_in.suggested_step;
        end
        if (r_state == S_CMP) begin
            r_match <= w_match & w_below;
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = (r_state == S_OUT);
    assign o_out.found         = r_found;
    assign o_out.member_count  = COUNT_W'(r_total);
    assign o_out.listed_member = w_list_ne ? w_val[0] : '0;
    assign o_out.listed_valid  = w_list_ne;
    assign o_out.last          = !w_list_ne || w_list_end;
    assign o_out.current_step  = w_step;
    assign o_out.status        = r_status;

    // checks
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(CAPACITY))
        else $error("member count above capacity");

    a_no_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(r_match))
        else $error("member present in more than one cell");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_add |=> (r_total == $past(r_total) + CNT_W'(1)))
        else $error("add did not grow the set");

    a_list_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && w_list_ne) |-> (r_cnt < r_total))
        else $error("list position past last member");

endmodule
